// ===== hw/rtl/daf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daf_pkg: shared types and constants for the damped angle follower
// Fixed-point formats, register indexes, controller states and the
// command and configuration bundles between controller and datapath.
// ----------------------------------------------------------------------------
package daf_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int RATE_W          = 40;
  localparam int POS_W           = 27;
  localparam int GAIN_W          = 16;
  localparam int DT_W            = 16;
  localparam int CFG_IDX_W       = 2;

  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER   = 90 << ANGLE_FRAC_BITS;
  localparam int THREE_Q   = 270 << ANGLE_FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_THRESHOLD = 2'd2;

  localparam logic [GAIN_W-1:0] TORQUE_GAIN_RST    = 16'd8192;
  localparam logic [GAIN_W-1:0] DRAG_GAIN_RST      = 16'd3686;
  localparam logic [GAIN_W-1:0] REST_THRESHOLD_RST = 16'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_M_TE,
    ST_M_DL,
    ST_M_DH,
    ST_A_FIN,
    ST_M_AL,
    ST_M_AH,
    ST_V_SUM,
    ST_V_FIN,
    ST_M_VL,
    ST_M_VH,
    ST_P_SUM,
    ST_P_FIN
  } daf_state_t;

  typedef enum logic [2:0] {
    MS_ERR_TG,
    MS_RLO_DG,
    MS_RHI_DG,
    MS_ALO_DT,
    MS_AHI_DT,
    MS_VLO_DT,
    MS_VHI_DT
  } daf_mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_SUB,
    ACC_SUB_HI,
    ACC_ADD_HI
  } daf_acc_op_t;

  typedef struct packed {
    logic         load;
    logic         calc_err;
    logic         mul_en;
    daf_mul_sel_t mul_sel;
    daf_acc_op_t  acc_op;
    logic         vel_en;
    logic         rest_en;
    logic         commit;
  } daf_cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] torque_gain;
    logic [GAIN_W-1:0] drag_gain;
    logic [GAIN_W-1:0] rest_threshold;
  } daf_cfg_t;

endpackage

// ===== hw/rtl/daf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daf_ctrl: sequencer for the damped angle follower
// Steps the shared multiplier and accumulator through one update and
// owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
module daf_ctrl import daf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output daf_cmd_t cmd
);

  daf_state_t state;
  daf_state_t state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.calc_err = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.mul_sel  = MS_ERR_TG;
    cmd.acc_op   = ACC_NONE;
    cmd.vel_en   = 1'b0;
    cmd.rest_en  = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = ST_M_TE;
      end
      ST_M_TE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ERR_TG;
        state_next  = ST_M_DL;
      end
      ST_M_DL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_RLO_DG;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_M_DH;
      end
      ST_M_DH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_RHI_DG;
        cmd.acc_op  = ACC_SUB;
        state_next  = ST_A_FIN;
      end
      ST_A_FIN: begin
        cmd.acc_op = ACC_SUB_HI;
        state_next = ST_M_AL;
      end
      ST_M_AL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ALO_DT;
        state_next  = ST_M_AH;
      end
      ST_M_AH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_AHI_DT;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_V_SUM;
      end
      ST_V_SUM: begin
        cmd.acc_op = ACC_ADD_HI;
        state_next = ST_V_FIN;
      end
      ST_V_FIN: begin
        cmd.vel_en = 1'b1;
        state_next = ST_M_VL;
      end
      ST_M_VL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_VLO_DT;
        cmd.rest_en = 1'b1;
        state_next  = ST_M_VH;
      end
      ST_M_VH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_VHI_DT;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_P_SUM;
      end
      ST_P_SUM: begin
        cmd.acc_op = ACC_ADD_HI;
        state_next = ST_P_FIN;
      end
      ST_P_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_ERR)
    else $error("accepted beat did not start an update");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken beat");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && state == ST_IDLE)
    else $error("committed result not presented");

  a_finish_stalls: assert property (@(posedge clk) disable iff (rst)
    state == ST_P_FIN && out_valid && !out_ready |=> state == ST_P_FIN)
    else $error("finish step left while output blocked");

endmodule

// ===== hw/rtl/daf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daf_dp: datapath for the damped angle follower
// Angle wrap and shortest-way error, one shared 28x17 multiplier, a
// product register, an accumulator, saturation and the needle state.
// ----------------------------------------------------------------------------
module daf_dp import daf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  daf_cmd_t          cmd,
  input  daf_cfg_t          cfg,
  input  logic [POS_W-1:0]  target_heading,
  input  logic [DT_W-1:0]   time_step,
  output logic [POS_W-1:0]  needle_position,
  output logic [RATE_W-1:0] needle_velocity,
  output logic              at_rest
);

  localparam int GAIN_SHIFT = 12;
  localparam int DT_SHIFT   = 16;
  localparam int ERR_W      = POS_W + 1;
  localparam int CMP_W      = POS_W + 2;
  localparam int MA_W       = 28;
  localparam int MB_W       = GAIN_W + 1;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int SPLIT      = 23;
  localparam int ACC_W      = RATE_W + 22;
  localparam int ACCEL_W    = RATE_W + 5;
  localparam int RHI_W      = RATE_W - SPLIT;
  localparam int AHI_W      = ACCEL_W - SPLIT;
  localparam int VSUM_W     = ACC_W - DT_SHIFT + 1;
  localparam int PSUM_W     = RATE_W + 1;

  localparam logic signed [POS_W:0]   FULL_P  = (POS_W + 1)'(FULL_TURN);
  localparam logic signed [CMP_W-1:0] FULL_C  = CMP_W'(FULL_TURN);
  localparam logic signed [CMP_W-1:0] QUART_C = CMP_W'(QUARTER);
  localparam logic signed [CMP_W-1:0] THREE_C = CMP_W'(THREE_Q);

  function automatic logic [POS_W-1:0] wrap_once(input logic [POS_W-1:0] a);
    logic signed [POS_W:0] t;
    t = $signed({a[POS_W-1], a});
    if (t < 0) t = t + FULL_P;
    if (t > FULL_P) t = t - FULL_P;
    return t[POS_W-1:0];
  endfunction

  logic [POS_W-1:0]         hw;
  logic [POS_W-1:0]         pw;
  logic [DT_W-1:0]          dt;
  logic [ERR_W-1:0]         err;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [POS_W-1:0]         needle_angle;
  logic [RATE_W-1:0]        needle_rate;
  logic                     rest;

  logic signed [CMP_W-1:0]  hx, px, d, alt_p, alt_n, mag_d, mag_ap, e;
  logic [ERR_W-1:0]         err_next;
  logic signed [MA_W-1:0]   a_op;
  logic signed [MB_W-1:0]   b_op;
  logic [ACCEL_W-1:0]       accel;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  prod_hi;
  logic signed [VSUM_W-1:0] vsum;
  logic [RATE_W-1:0]        vel_next;
  logic [RATE_W:0]          rate_mag;
  logic signed [PSUM_W-1:0] psum;
  logic [POS_W-1:0]         pos_next;

  // shortest-way error
  always_comb begin
    hx     = $signed({{2{hw[POS_W-1]}}, hw});
    px     = $signed({{2{pw[POS_W-1]}}, pw});
    d      = hx - px;
    alt_p  = d - FULL_C;
    alt_n  = d + FULL_C;
    mag_d  = (d < 0) ? -d : d;
    mag_ap = (alt_p < 0) ? -alt_p : alt_p;
    e      = d;
    if (hx > THREE_C && px < QUART_C) begin
      e = hx - FULL_C - px;
    end else if (hx < QUART_C && px > THREE_C) begin
      e = hx + FULL_C - px;
    end else if (d > 0) begin
      if (mag_ap < d) e = alt_p;
    end else if (d < 0) begin
      if (alt_n < mag_d) e = alt_n;
    end
    err_next = e[ERR_W-1:0];
  end

  assign accel = acc[GAIN_SHIFT +: ACCEL_W];

  // multiplier operands: wide values go as unsigned low part, signed high part
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cmd.mul_sel)
      MS_ERR_TG: begin
        a_op = $signed(err);
        b_op = $signed({1'b0, cfg.torque_gain});
      end
      MS_RLO_DG: begin
        a_op = $signed({{(MA_W - SPLIT){1'b0}}, needle_rate[SPLIT-1:0]});
        b_op = $signed({1'b0, cfg.drag_gain});
      end
      MS_RHI_DG: begin
        a_op = $signed({{(MA_W - RHI_W){needle_rate[RATE_W-1]}},
                        needle_rate[RATE_W-1:SPLIT]});
        b_op = $signed({1'b0, cfg.drag_gain});
      end
      MS_ALO_DT: begin
        a_op = $signed({{(MA_W - SPLIT){1'b0}}, accel[SPLIT-1:0]});
        b_op = $signed({1'b0, dt});
      end
      MS_AHI_DT: begin
        a_op = $signed({{(MA_W - AHI_W){accel[ACCEL_W-1]}}, accel[ACCEL_W-1:SPLIT]});
        b_op = $signed({1'b0, dt});
      end
      MS_VLO_DT: begin
        a_op = $signed({{(MA_W - SPLIT){1'b0}}, needle_rate[SPLIT-1:0]});
        b_op = $signed({1'b0, dt});
      end
      MS_VHI_DT: begin
        a_op = $signed({{(MA_W - RHI_W){needle_rate[RATE_W-1]}},
                        needle_rate[RATE_W-1:SPLIT]});
        b_op = $signed({1'b0, dt});
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_ext = $signed({{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod});
  assign prod_hi  = prod_ext <<< SPLIT;

  // velocity: floor shift, add, saturate
  always_comb begin
    vsum = $signed({{(VSUM_W - RATE_W){needle_rate[RATE_W-1]}}, needle_rate})
         + $signed({acc[ACC_W-1], acc[ACC_W-1:DT_SHIFT]});
    if (&vsum[VSUM_W-1:RATE_W-1] || ~|vsum[VSUM_W-1:RATE_W-1]) begin
      vel_next = vsum[RATE_W-1:0];
    end else if (vsum[VSUM_W-1]) begin
      vel_next = {1'b1, {(RATE_W - 1){1'b0}}};
    end else begin
      vel_next = {1'b0, {(RATE_W - 1){1'b1}}};
    end
  end

  assign rate_mag = needle_rate[RATE_W-1] ?
                    (RATE_W + 1)'(-$signed({needle_rate[RATE_W-1], needle_rate})) :
                    {1'b0, needle_rate};

  // position: hold at rest, else add and saturate
  always_comb begin
    psum = $signed({{(PSUM_W - POS_W){pw[POS_W-1]}}, pw})
         + $signed(acc[DT_SHIFT +: PSUM_W]);
    if (rest) begin
      pos_next = pw;
    end else if (&psum[PSUM_W-1:POS_W-1] || ~|psum[PSUM_W-1:POS_W-1]) begin
      pos_next = psum[POS_W-1:0];
    end else if (psum[PSUM_W-1]) begin
      pos_next = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      pos_next = {1'b0, {(POS_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hw <= wrap_once(target_heading);
      pw <= wrap_once(needle_angle);
      dt <= time_step;
    end
    if (cmd.calc_err) begin
      err <= err_next;
    end
    if (cmd.mul_en) begin
      prod <= a_op * b_op;
    end
    case (cmd.acc_op)
      ACC_LOAD:   acc <= prod_ext;
      ACC_SUB:    acc <= acc - prod_ext;
      ACC_SUB_HI: acc <= acc - prod_hi;
      ACC_ADD_HI: acc <= acc + prod_hi;
      default:    acc <= acc;
    endcase
    if (cmd.rest_en) begin
      rest <= rate_mag < {{(RATE_W + 1 - GAIN_W){1'b0}}, cfg.rest_threshold};
    end
    if (cmd.commit) begin
      needle_position <= pos_next;
      needle_velocity <= needle_rate;
      at_rest         <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_angle <= '0;
      needle_rate  <= '0;
    end else begin
      if (cmd.vel_en) needle_rate <= vel_next;
      if (cmd.commit) needle_angle <= pos_next;
    end
  end

endmodule

// ===== hw/rtl/damped_angle_follower.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_angle_follower: spring-damper needle that tracks a target heading
// Configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each accepted beat of target_heading and time_step yields one result beat:
// the updated needle position, velocity and an at_rest flag. The next input
// beat is accepted only after the current update commits its result, and the
// commit waits while the previous result has not yet been taken. The update
// runs on one shared 28x17 multiplier that forms seven partial products in
// turn (gain times error, drag times velocity, acceleration times step,
// velocity times step), each folded into the accumulator the cycle after.
// A new input is taken while the previous result waits in the output
// register. Configuration writes are taken every cycle and belong only
// between updates.
// ----------------------------------------------------------------------------
module damped_angle_follower import daf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [POS_W-1:0]     target_heading,
  input  logic [DT_W-1:0]      time_step,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic [POS_W-1:0]     needle_position,
  output logic [RATE_W-1:0]    needle_velocity,
  output logic                 at_rest,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  daf_cfg_t cfg;
  daf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.torque_gain    <= TORQUE_GAIN_RST;
      cfg.drag_gain      <= DRAG_GAIN_RST;
      cfg.rest_threshold <= REST_THRESHOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TORQUE_GAIN:    cfg.torque_gain    <= cfg_data;
        REG_DRAG_GAIN:      cfg.drag_gain      <= cfg_data;
        REG_REST_THRESHOLD: cfg.rest_threshold <= cfg_data;
        default:            cfg <= cfg;
      endcase
    end
  end

  daf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  daf_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .target_heading  (target_heading),
    .time_step       (time_step),
    .needle_position (needle_position),
    .needle_velocity (needle_velocity),
    .at_rest         (at_rest)
  );

endmodule
